### src/dtc_pkg.sv
// Shared constants, lookup functions and inter-stage types for the date to
// calendar fields pipeline. No dependencies.
package dtc_pkg;

  // The year is biased by 400 so that the year before any input stays positive.
  localparam logic [14:0] YEAR_BIAS = 15'd400;

  // Reciprocal for division by 100; exact for every biased year below 43690.
  localparam logic [14:0] DIV100_MUL   = 15'd20972;
  localparam int          DIV100_SHIFT = 21;

  // Reciprocal for division by 7; exact for dividends below 682.
  localparam logic [9:0] DIV7_MUL   = 10'd586;
  localparam int         DIV7_SHIFT = 12;

  localparam logic [5:0] WEEKS_LONG  = 6'd53;
  localparam logic [5:0] WEEKS_SHORT = 6'd52;
  localparam logic [8:0] DAYS_LEAP   = 9'd366;
  localparam logic [8:0] DAYS_COMMON = 9'd365;

  typedef struct packed {
    logic [14:0] s_sum;      // y + y/4 - y/100 + y/400 of the biased year
    logic        leap;
    logic        leap_prev;  // leap flag of the year before
    logic [3:0]  month;
    logic [4:0]  day;
  } year_info_t;

  typedef struct packed {
    logic [2:0] smod;        // s_sum mod 7
    logic [2:0] smod_prev;   // the same sum for the year before, mod 7
    logic [8:0] ord;
    logic [4:0] mlen;
    logic       leap;
    logic       leap_prev;
    logic       bad;
    logic [3:0] month;
    logic [4:0] day;
  } date_info_t;

  typedef struct packed {
    logic [2:0] weekday;
    logic [8:0] num;         // ordinal day + 9 - weekday
    logic       long_cur;    // this year has 53 ISO weeks
    logic       long_prev;   // the year before has 53 ISO weeks
    logic [8:0] ord;
    logic [4:0] mlen;
    logic       leap;
    logic       bad;
  } week_info_t;

  // Residue mod 7 of a 6-bit value below 63, using 8 = 1 (mod 7).
  function automatic logic [2:0] mod7_6b(input logic [5:0] x);
    logic [3:0] t;
    t = {1'b0, x[5:3]} + {1'b0, x[2:0]};
    if (t >= 4'd7) begin
      t = t - 4'd7;
    end
    return t[2:0];
  endfunction

  function automatic logic [2:0] mod7_15b(input logic [14:0] x);
    logic [5:0] s;
    s = 6'(x[14:12]) + 6'(x[11:9]) + 6'(x[8:6]) + 6'(x[5:3]) + 6'(x[2:0]);
    return mod7_6b(s);
  endfunction

  // Sunday-based weekday to Monday-based weekday.
  function automatic logic [2:0] monday_based(input logic [2:0] sun);
    return (sun == 3'd0) ? 3'd6 : 3'(sun - 3'd1);
  endfunction

  function automatic logic [2:0] month_offset(input logic [3:0] m);
    logic [2:0] r;
    unique case (m)
      4'd1:    r = 3'd0;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd2;
      4'd4:    r = 3'd5;
      4'd5:    r = 3'd0;
      4'd6:    r = 3'd3;
      4'd7:    r = 3'd5;
      4'd8:    r = 3'd1;
      4'd9:    r = 3'd4;
      4'd10:   r = 3'd6;
      4'd11:   r = 3'd2;
      4'd12:   r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Days in a month; zero for a month number that means nothing.
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
      4'd2:    r = leap ? 5'd29 : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Days in a common year before the first of the month.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

### src/dtc_year_stage.sv
// Pipeline stages 1 and 2: biased year, division by 100 through a reciprocal
// multiply, leap flags and the Sakamoto year sum. Depends on dtc_pkg.
module dtc_year_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [13:0]            in_year,
  input  logic [3:0]             in_month,
  input  logic [4:0]             in_day,
  output logic                   out_valid,
  output dtc_pkg::year_info_t    out_info
);

  logic        v1_r;
  logic [14:0] y1_r;
  logic [28:0] prod1_r;
  logic [3:0]  month1_r;
  logic [4:0]  day1_r;
  logic [14:0] y_nxt;
  logic [28:0] prod_nxt;

  logic                v2_r;
  dtc_pkg::year_info_t info2_r;
  dtc_pkg::year_info_t info2_nxt;
  logic [7:0]          q100;
  logic [6:0]          r100;

  assign y_nxt    = 15'(in_year) + dtc_pkg::YEAR_BIAS;
  assign prod_nxt = 29'(y_nxt) * 29'(dtc_pkg::DIV100_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    y1_r     <= y_nxt;
    prod1_r  <= prod_nxt;
    month1_r <= in_month;
    day1_r   <= in_day;
  end

  assign q100 = prod1_r[dtc_pkg::DIV100_SHIFT +: 8];
  assign r100 = 7'(y1_r - 15'(q100) * 15'd100);

  // The year before has y - 1 = 100 * q100 exactly when the remainder is one.
  always_comb begin
    info2_nxt           = '0;
    info2_nxt.leap      = ((y1_r[1:0] == 2'd0) && (r100 != 7'd0))
                          || ((r100 == 7'd0) && (q100[1:0] == 2'd0));
    info2_nxt.leap_prev = ((y1_r[1:0] == 2'd1) && (r100 != 7'd1))
                          || ((r100 == 7'd1) && (q100[1:0] == 2'd0));
    info2_nxt.s_sum     = y1_r + {2'b00, y1_r[14:2]} - 15'(q100) + 15'(q100[7:2]);
    info2_nxt.month     = month1_r;
    info2_nxt.day       = day1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    info2_r <= info2_nxt;
  end

  assign out_valid = v2_r;
  assign out_info  = info2_r;

endmodule

### src/dtc_date_stage.sv
// Pipeline stage 3: year sums mod 7, month length, date check and ordinal day.
// Depends on dtc_pkg.
module dtc_date_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  dtc_pkg::year_info_t    in_info,
  output logic                   out_valid,
  output dtc_pkg::date_info_t    out_info
);

  logic                v3_r;
  dtc_pkg::date_info_t info3_r;
  dtc_pkg::date_info_t info3_nxt;
  logic [2:0]          smod;
  logic [3:0]          prev_sum;
  logic [4:0]          mlen;

  assign smod = dtc_pkg::mod7_15b(in_info.s_sum);
  // The sum drops by one plus the leap flag from one year to the one before.
  assign prev_sum = 4'(smod) + 4'd6 - 4'(in_info.leap);
  assign mlen = dtc_pkg::month_days(in_info.month, in_info.leap);

  always_comb begin
    info3_nxt           = '0;
    info3_nxt.smod      = smod;
    info3_nxt.smod_prev = (prev_sum >= 4'd7) ? 3'(prev_sum - 4'd7) : prev_sum[2:0];
    info3_nxt.mlen      = mlen;
    info3_nxt.ord       = 9'(in_info.day) + dtc_pkg::days_before(in_info.month)
                          + 9'(in_info.leap && (in_info.month > 4'd2));
    info3_nxt.leap      = in_info.leap;
    info3_nxt.leap_prev = in_info.leap_prev;
    // An invalid month has a length of zero, so only a zero day needs its own test.
    info3_nxt.bad       = (in_info.day == 5'd0) || (in_info.day > mlen);
    info3_nxt.month     = in_info.month;
    info3_nxt.day       = in_info.day;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= in_valid;
    end
    info3_r <= info3_nxt;
  end

  assign out_valid = v3_r;
  assign out_info  = info3_r;

endmodule

### src/dtc_week_stage.sv
// Pipeline stages 4 and 5: weekday, ISO week counts of this and the previous
// year, week division by 7 and the output register. Depends on dtc_pkg.
module dtc_week_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  dtc_pkg::date_info_t    in_info,
  output logic                   out_valid,
  output logic [2:0]             out_weekday,
  output logic [5:0]             out_iso_week,
  output logic [8:0]             out_ordinal_day,
  output logic [8:0]             out_year_length,
  output logic [4:0]             out_month_length,
  output logic                   out_leap,
  output logic                   out_bad_date
);

  logic                v4_r;
  dtc_pkg::week_info_t info4_r;
  dtc_pkg::week_info_t info4_nxt;
  logic [2:0]          s_yy;
  logic [2:0]          sun;
  logic [2:0]          wd;
  logic [2:0]          last_cur;
  logic [2:0]          last_prev;

  logic        valid_r;
  logic [2:0]  weekday_r;
  logic [5:0]  iso_week_r;
  logic [8:0]  ordinal_day_r;
  logic [8:0]  year_length_r;
  logic [4:0]  month_length_r;
  logic        leap_r;
  logic        bad_date_r;
  logic [17:0] prod7;
  logic [5:0]  wk_raw;
  logic [5:0]  weeks_cur;
  logic [5:0]  wk;

  // January and February count against the year before.
  assign s_yy = (in_info.month < 4'd3) ? in_info.smod_prev : in_info.smod;
  assign sun  = dtc_pkg::mod7_6b(6'(s_yy) + 6'(dtc_pkg::month_offset(in_info.month))
                                 + 6'(in_info.day));
  assign wd   = dtc_pkg::monday_based(sun);
  // December 31 adds a multiple of 7 to the year sum.
  assign last_cur  = dtc_pkg::monday_based(in_info.smod);
  assign last_prev = dtc_pkg::monday_based(in_info.smod_prev);

  always_comb begin
    info4_nxt           = '0;
    info4_nxt.weekday   = wd;
    info4_nxt.num       = in_info.ord + 9'd9 - 9'(wd);
    info4_nxt.long_cur  = (last_cur == 3'd3) || ((last_cur == 3'd4) && in_info.leap);
    info4_nxt.long_prev = (last_prev == 3'd3) || ((last_prev == 3'd4) && in_info.leap_prev);
    info4_nxt.ord       = in_info.ord;
    info4_nxt.mlen      = in_info.mlen;
    info4_nxt.leap      = in_info.leap;
    info4_nxt.bad       = in_info.bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= in_valid;
    end
    info4_r <= info4_nxt;
  end

  assign prod7     = 18'(info4_r.num) * 18'(dtc_pkg::DIV7_MUL);
  assign wk_raw    = prod7[dtc_pkg::DIV7_SHIFT +: 6];
  assign weeks_cur = info4_r.long_cur ? dtc_pkg::WEEKS_LONG : dtc_pkg::WEEKS_SHORT;

  always_comb begin
    if (wk_raw == 6'd0) begin
      wk = info4_r.long_prev ? dtc_pkg::WEEKS_LONG : dtc_pkg::WEEKS_SHORT;
    end else if (wk_raw > weeks_cur) begin
      wk = 6'd1;
    end else begin
      wk = wk_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= v4_r;
    end
    if (info4_r.bad) begin
      weekday_r      <= '0;
      iso_week_r     <= '0;
      ordinal_day_r  <= '0;
      year_length_r  <= '0;
      month_length_r <= '0;
      leap_r         <= 1'b0;
      bad_date_r     <= 1'b1;
    end else begin
      weekday_r      <= info4_r.weekday;
      iso_week_r     <= wk;
      ordinal_day_r  <= info4_r.ord;
      year_length_r  <= info4_r.leap ? dtc_pkg::DAYS_LEAP : dtc_pkg::DAYS_COMMON;
      month_length_r <= info4_r.mlen;
      leap_r         <= info4_r.leap;
      bad_date_r     <= 1'b0;
    end
  end

  assign out_valid        = valid_r;
  assign out_weekday      = weekday_r;
  assign out_iso_week     = iso_week_r;
  assign out_ordinal_day  = ordinal_day_r;
  assign out_year_length  = year_length_r;
  assign out_month_length = month_length_r;
  assign out_leap         = leap_r;
  assign out_bad_date     = bad_date_r;

endmodule

### src/date_to_calendar_fields_core.sv
// Top level of the date to calendar fields pipeline: three stage modules and
// checks. Depends on dtc_pkg, dtc_year_stage, dtc_date_stage, dtc_week_stage.

// A date word is taken on every clock edge at which start is high; busy is
// always low, so one date per cycle is accepted without gaps. Each result word
// appears with out_valid high for one cycle, in input order; the receiver
// cannot stall, so nothing is held back. The pipeline has five register
// stages: the reciprocal multiply that divides the biased year by 100, the
// leap flags and year sum, the mod-7 reduction with month tables, the weekday
// and week counts, and the division by 7 feeding the output register. An
// invalid month or day sets out_bad_date and zeroes every other field.
module date_to_calendar_fields_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [13:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  output logic        out_valid,
  output logic [2:0]  out_weekday,
  output logic [5:0]  out_iso_week,
  output logic [8:0]  out_ordinal_day,
  output logic [8:0]  out_year_length,
  output logic [4:0]  out_month_length,
  output logic        out_leap,
  output logic        out_bad_date
);

  logic                accept;
  logic                yr_valid;
  dtc_pkg::year_info_t yr_info;
  logic                dt_valid;
  dtc_pkg::date_info_t dt_info;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  dtc_year_stage u_year (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_year   (in_year),
    .in_month  (in_month),
    .in_day    (in_day),
    .out_valid (yr_valid),
    .out_info  (yr_info)
  );

  dtc_date_stage u_date (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (yr_valid),
    .in_info   (yr_info),
    .out_valid (dt_valid),
    .out_info  (dt_info)
  );

  dtc_week_stage u_week (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (dt_valid),
    .in_info          (dt_info),
    .out_valid        (out_valid),
    .out_weekday      (out_weekday),
    .out_iso_week     (out_iso_week),
    .out_ordinal_day  (out_ordinal_day),
    .out_year_length  (out_year_length),
    .out_month_length (out_month_length),
    .out_leap         (out_leap),
    .out_bad_date     (out_bad_date)
  );

  // Every accepted date comes out as a result word.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##5 out_valid)
    else $error("accepted date did not produce a result word");

  // No result word without a matching accepted date.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 5))
    else $error("result word without a matching accepted date");

  // A bad date clears every other field.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_date) |-> (out_iso_week == 6'd0) && (out_ordinal_day == 9'd0)
      && (out_year_length == 9'd0) && (out_month_length == 5'd0) && !out_leap
      && (out_weekday == 3'd0))
    else $error("bad date word carries nonzero fields");

  // A good date has consistent week, year and ordinal fields.
  a_good_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_bad_date) |-> (out_iso_week >= 6'd1) && (out_iso_week <= 6'd53)
      && (out_ordinal_day >= 9'd1) && (out_ordinal_day <= out_year_length)
      && (out_leap == (out_year_length == 9'd366)) && (out_weekday <= 3'd6))
    else $error("good date word has inconsistent fields");

endmodule
